// ===== sv/mncc_pkg.sv =====
// Shared types and codes for the masked normalized cross-correlation block.
package mncc_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD_X,
      ST_ADD_A,
      ST_ADD_B,
      ST_CHECK,
      ST_MUL_P,
      ST_LOAD_T,
      ST_MUL_T,
      ST_CMP,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

   // Operand pairing of the pixel multiplier
   typedef enum logic [1:0] {
      MUL_AB,
      MUL_AA,
      MUL_BB
   } mul_sel_type;

   // Control word from the sequencer to the pixel multiplier
   typedef struct packed {
      logic        enable;
      mul_sel_type sel;
   } mul_ctrl_type;

   // Register index codes, taken from paddr[2]
   localparam logic REG_MASK_ENABLE = 1'b0;
   localparam logic REG_MASK_INVERT = 1'b1;

endpackage

// ===== sv/mncc_addsub.sv =====
// Shared wide adder/subtractor used by the accumulate, multiply, divide and root steps of the sequencer.
module mncc_addsub import mncc_pkg::*; #(
   parameter int WIDTH = 112
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             subtract,
   output logic [WIDTH-1:0] result,
   output logic             carry
);

   logic [WIDTH-1:0] op_b_eff;

   // Invert and add one for subtraction; carry out then means op_a >= op_b
   assign op_b_eff = subtract ? ~op_b : op_b;
   assign {carry, result} = {1'b0, op_a} + {1'b0, op_b_eff} + (WIDTH+1)'(subtract);

endmodule

// ===== sv/mncc_pixmul.sv =====
// Registered signed pixel multiplier, shared over the three products of a pixel pair.
module mncc_pixmul import mncc_pkg::*; #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                           clock,
   input  logic signed [PIXEL_BITS-1:0]   pixel_a,
   input  logic signed [PIXEL_BITS-1:0]   pixel_b,
   input  mul_ctrl_type                   ctrl,
   output logic signed [2*PIXEL_BITS-1:0] product
);

   logic signed [PIXEL_BITS-1:0]   mul_x;
   logic signed [PIXEL_BITS-1:0]   mul_y;
   logic signed [2*PIXEL_BITS-1:0] product_ff;
   logic signed [2*PIXEL_BITS-1:0] product_in;

   // Pick the operand pair for this cycle
   always_comb begin
      mul_x = pixel_a;
      mul_y = pixel_b;
      unique case (ctrl.sel)
         MUL_AB: begin
            mul_x = pixel_a;
            mul_y = pixel_b;
         end
         MUL_AA: begin
            mul_x = pixel_a;
            mul_y = pixel_a;
         end
         MUL_BB: begin
            mul_x = pixel_b;
            mul_y = pixel_b;
         end
         default: begin
            mul_x = pixel_a;
            mul_y = pixel_b;
         end
      endcase
      product_in = mul_x * mul_y;
   end

   // Hold the product until the next multiply
   always_ff @(posedge clock) begin
      if (ctrl.enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== sv/masked_normalized_cross_correlation.sv =====
// Top level of the masked normalized cross-correlation block: ports, sequencer and datapath.
//
// Pixel pairs stream in on req_*, one word per pair; pairs that the stencil selects and whose
// pixels are both nonzero add a*b, a*a and b*b into exact sums. A word with tlast closes the
// image pair and one word leaves on rsp_*: sum_ab / sqrt(sum_aa * sum_bb) in signed Q1.F
// (F = FRACTION_BITS), truncated toward zero, with tuser set and data zero when a square sum
// is zero. A counted pixel's three products go one after another through a single registered
// multiplier and a single adder. After the last pixel, all on one shared wide adder, come two
// shift-add multiplies of CW steps each (CW = 2*PIXEL_BITS + MAX_PIXELS_LOG2), a long division
// of 2*F steps and a square root of F steps; a result that saturates skips the division and
// the root. Empty sums go straight from the check to the result word. The final word waits
// only if the previous result has not been taken. mask_enable and mask_invert sit at byte
// addresses 0 and 4 of the csr port.
module masked_normalized_cross_correlation import mncc_pkg::*; #(
   parameter  int PIXEL_BITS      = 16,
   parameter  int MAX_PIXELS_LOG2 = 24,
   parameter  int FRACTION_BITS   = 16,
   localparam int REQ_DW          = ((2 * PIXEL_BITS + 7) / 8) * 8,
   localparam int RSP_DW          = ((FRACTION_BITS + 2 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // Pixel words
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // pixel_a, pixel_b, zero fill
   input  logic              req_tlast,   // last_pixel
   input  logic              req_tuser,   // in_mask
   // Result words
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // correlation, zero fill
   output logic              rsp_tuser,   // empty_res
   // Configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CW    = 2 * PIXEL_BITS + MAX_PIXELS_LOG2;
   localparam int SW    = CW - 1;
   localparam int WW    = 2 * CW;
   localparam int PW    = 2 * PIXEL_BITS;
   localparam int QW    = 2 * FRACTION_BITS;
   localparam int RW    = FRACTION_BITS + 2;
   localparam int MAXIT = (CW > QW) ? CW : QW;
   localparam int CNTW  = $clog2(MAXIT);

   localparam logic [CNTW-1:0]      MUL_LAST  = CNTW'(CW - 1);
   localparam logic [CNTW-1:0]      DIV_LAST  = CNTW'(QW - 1);
   localparam logic [CNTW-1:0]      SQRT_LAST = CNTW'(FRACTION_BITS - 1);
   localparam logic signed [RW-1:0] CORR_MAX  = {2'b01, {FRACTION_BITS{1'b0}}};
   localparam logic signed [RW-1:0] CORR_MIN  = {2'b11, {FRACTION_BITS{1'b0}}};

   state_type state_ff, state_in;

   logic mask_enable_ff, mask_enable_in;
   logic mask_invert_ff, mask_invert_in;

   logic signed [PIXEL_BITS-1:0] pixel_a_ff, pixel_a_in;
   logic signed [PIXEL_BITS-1:0] pixel_b_ff, pixel_b_in;
   logic                         last_ff, last_in;

   logic [CW-1:0] sum_cross_ff, sum_cross_in;
   logic [SW-1:0] sum_sq_a_ff, sum_sq_a_in;
   logic [SW-1:0] sum_sq_b_ff, sum_sq_b_in;

   logic                     neg_ff, neg_in;
   logic                     empty_ff, empty_in;
   logic                     sat_ff, sat_in;
   logic [CW-1:0]            mag_ff, mag_in;
   logic [CW-1:0]            mcand_ff, mcand_in;
   logic [CW-1:0]            mplier_ff, mplier_in;
   logic [WW-1:0]            acc_ff, acc_in;
   logic [WW-1:0]            p_ff, p_in;
   logic [QW-1:0]            quo_ff, quo_in;
   logic [RW-1:0]            rem_ff, rem_in;
   logic [FRACTION_BITS-1:0] root_ff, root_in;
   logic [CNTW-1:0]          cnt_ff, cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0] corr_ff, corr_in;
   logic          rsp_empty_ff, rsp_empty_in;

   logic signed [PIXEL_BITS-1:0] in_pixel_a;
   logic signed [PIXEL_BITS-1:0] in_pixel_b;
   logic                         selected;
   logic                         counted;
   logic                         accept;
   logic                         csr_write;
   logic                         sums_zero;
   logic                         rsp_load;
   logic [RW-1:0]                trial_rem;
   logic [RW-1:0]                q_mag;

   mul_ctrl_type             mul_ctrl;
   logic signed [PW-1:0]     product;
   logic [WW-1:0]            product_ext;
   logic [WW-1:0]            add_a;
   logic [WW-1:0]            add_b;
   logic                     add_sub;
   logic [WW-1:0]            add_result;
   logic                     add_carry;

   // Unpack the pixel word and decide whether it counts
   assign in_pixel_a = req_tdata[PIXEL_BITS-1:0];
   assign in_pixel_b = req_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
   assign selected   = mask_enable_ff ? (req_tuser ^ mask_invert_ff) : 1'b1;
   assign counted    = selected && (in_pixel_a != '0) && (in_pixel_b != '0);
   assign accept     = req_tvalid && req_tready;

   assign sums_zero   = (sum_sq_a_ff == '0) || (sum_sq_b_ff == '0);
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign product_ext = {{(WW-PW){product[PW-1]}}, product};
   assign trial_rem   = {rem_ff[FRACTION_BITS-1:0], quo_ff[QW-1:QW-2]};
   assign q_mag       = sat_ff ? RW'(CORR_MAX) : RW'(root_ff);

   mncc_pixmul #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_pixmul (
      .clock   (clock),
      .pixel_a (pixel_a_ff),
      .pixel_b (pixel_b_ff),
      .ctrl    (mul_ctrl),
      .product (product)
   );

   mncc_addsub #(
      .WIDTH (WW)
   ) u_addsub (
      .op_a     (add_a),
      .op_b     (add_b),
      .subtract (add_sub),
      .result   (add_result),
      .carry    (add_carry)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (counted) begin
                  state_in = ST_MUL;
               end else if (req_tlast) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_MUL:   state_in = ST_ADD_X;
         ST_ADD_X: state_in = ST_ADD_A;
         ST_ADD_A: state_in = ST_ADD_B;
         ST_ADD_B: state_in = last_ff ? ST_CHECK : ST_IDLE;
         ST_CHECK: state_in = sums_zero ? ST_DONE : ST_MUL_P;
         ST_MUL_P: begin
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_LOAD_T;
            end
         end
         ST_LOAD_T: state_in = ST_MUL_T;
         ST_MUL_T: begin
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: state_in = add_carry ? ST_DONE : ST_DIV;
         ST_DIV: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (cnt_ff == SQRT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, multiplier control and adder operands
   always_comb begin
      req_tready = 1'b0;
      mul_ctrl   = '{enable: 1'b0, sel: MUL_AB};
      add_a      = '0;
      add_b      = '0;
      add_sub    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_MUL: begin
            mul_ctrl = '{enable: 1'b1, sel: MUL_AB};
         end
         ST_ADD_X: begin
            mul_ctrl = '{enable: 1'b1, sel: MUL_AA};
            add_a    = WW'(sum_cross_ff);
            add_b    = product_ext;
         end
         ST_ADD_A: begin
            mul_ctrl = '{enable: 1'b1, sel: MUL_BB};
            add_a    = WW'(sum_sq_a_ff);
            add_b    = product_ext;
         end
         ST_ADD_B: begin
            add_a = WW'(sum_sq_b_ff);
            add_b = product_ext;
         end
         ST_CHECK: begin
            // Negate the cross sum for its magnitude
            add_b   = WW'(sum_cross_ff);
            add_sub = 1'b1;
         end
         ST_MUL_P, ST_MUL_T: begin
            add_a = {acc_ff[WW-2:0], 1'b0};
            add_b = mplier_ff[CW-1] ? WW'(mcand_ff) : '0;
         end
         ST_CMP: begin
            add_a   = acc_ff;
            add_b   = p_ff;
            add_sub = 1'b1;
         end
         ST_DIV: begin
            add_a   = {acc_ff[WW-2:0], 1'b0};
            add_b   = p_ff;
            add_sub = 1'b1;
         end
         ST_SQRT: begin
            add_a   = WW'(trial_rem);
            add_b   = WW'({root_ff, 2'b01});
            add_sub = 1'b1;
         end
         ST_LOAD_T, ST_DONE: begin
            add_sub = 1'b0;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      pixel_a_in   = pixel_a_ff;
      pixel_b_in   = pixel_b_ff;
      last_in      = last_ff;
      sum_cross_in = sum_cross_ff;
      sum_sq_a_in  = sum_sq_a_ff;
      sum_sq_b_in  = sum_sq_b_ff;
      neg_in       = neg_ff;
      empty_in     = empty_ff;
      sat_in       = sat_ff;
      mag_in       = mag_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      corr_in      = corr_ff;
      rsp_empty_in = rsp_empty_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pixel_a_in = in_pixel_a;
               pixel_b_in = in_pixel_b;
               last_in    = req_tlast;
            end
         end
         ST_ADD_X: sum_cross_in = add_result[CW-1:0];
         ST_ADD_A: sum_sq_a_in  = add_result[SW-1:0];
         ST_ADD_B: sum_sq_b_in  = add_result[SW-1:0];
         ST_CHECK: begin
            // Take the sign and magnitude, load sum_aa * sum_bb
            empty_in  = sums_zero;
            sat_in    = 1'b0;
            neg_in    = sum_cross_ff[CW-1];
            mag_in    = sum_cross_ff[CW-1] ? add_result[CW-1:0] : sum_cross_ff;
            mcand_in  = CW'(sum_sq_a_ff);
            mplier_in = CW'(sum_sq_b_ff);
            acc_in    = '0;
            cnt_in    = '0;
         end
         ST_MUL_P, ST_MUL_T: begin
            acc_in    = add_result;
            mplier_in = {mplier_ff[CW-2:0], 1'b0};
            cnt_in    = cnt_ff + CNTW'(1);
         end
         ST_LOAD_T: begin
            // Park the square-sum product, load magnitude squared
            p_in      = acc_ff;
            mcand_in  = mag_ff;
            mplier_in = mag_ff;
            acc_in    = '0;
            cnt_in    = '0;
         end
         ST_CMP: begin
            // Saturate when the cross square reaches the product
            sat_in  = add_carry;
            cnt_in  = '0;
            quo_in  = '0;
            rem_in  = '0;
            root_in = '0;
         end
         ST_DIV: begin
            // Restart the count for the root after the last quotient bit
            acc_in = add_carry ? add_result : {acc_ff[WW-2:0], 1'b0};
            quo_in = {quo_ff[QW-2:0], add_carry};
            cnt_in = (cnt_ff == DIV_LAST) ? '0 : cnt_ff + CNTW'(1);
         end
         ST_SQRT: begin
            quo_in  = {quo_ff[QW-3:0], 2'b00};
            rem_in  = add_carry ? add_result[RW-1:0] : trial_rem;
            root_in = {root_ff[FRACTION_BITS-2:0], add_carry};
            cnt_in  = cnt_ff + CNTW'(1);
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = empty_ff;
               if (empty_ff) begin
                  corr_in = '0;
               end else begin
                  corr_in = neg_ff ? (~q_mag) + RW'(1) : q_mag;
               end
               sum_cross_in = '0;
               sum_sq_a_in  = '0;
               sum_sq_b_in  = '0;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Configuration register writes
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mask_enable_in = mask_enable_ff;
      mask_invert_in = mask_invert_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_MASK_ENABLE: mask_enable_in = csr_pwdata[0];
            REG_MASK_INVERT: mask_invert_in = csr_pwdata[0];
            default:         mask_enable_in = mask_enable_ff;
         endcase
      end
   end

   // Configuration readback
   always_comb begin
      unique case (csr_paddr[2])
         REG_MASK_ENABLE: csr_prdata = 32'(mask_enable_ff);
         REG_MASK_INVERT: csr_prdata = 32'(mask_invert_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // Control and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mask_enable_ff <= 1'b0;
         mask_invert_ff <= 1'b0;
         sum_cross_ff   <= '0;
         sum_sq_a_ff    <= '0;
         sum_sq_b_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mask_enable_ff <= mask_enable_in;
         mask_invert_ff <= mask_invert_in;
         sum_cross_ff   <= sum_cross_in;
         sum_sq_a_ff    <= sum_sq_a_in;
         sum_sq_b_ff    <= sum_sq_b_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pixel_a_ff   <= pixel_a_in;
      pixel_b_ff   <= pixel_b_in;
      last_ff      <= last_in;
      neg_ff       <= neg_in;
      empty_ff     <= empty_in;
      sat_ff       <= sat_in;
      mag_ff       <= mag_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      acc_ff       <= acc_in;
      p_ff         <= p_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      cnt_ff       <= cnt_in;
      corr_ff      <= corr_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Result word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'(corr_ff);
   assign rsp_tuser  = rsp_empty_ff;

   // Division remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (acc_ff < p_ff))
      else $error("division remainder not below divisor");

   // An empty result carries a zero correlation
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (corr_ff == '0))
      else $error("empty result with nonzero correlation");

   // Correlation stays within plus or minus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (($signed(corr_ff) <= CORR_MAX) && ($signed(corr_ff) >= CORR_MIN)))
      else $error("correlation out of range");

   // Sums are clear once a result has been loaded
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (state_in == ST_IDLE)) |=>
         ((sum_cross_ff == '0) && (sum_sq_a_ff == '0) && (sum_sq_b_ff == '0)))
      else $error("sums not cleared after result");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the masked normalized cross-correlation block.
module tb;
   import mncc_pkg::*;

   typedef logic signed [15:0] pixel_type;

   typedef struct packed {
      logic [17:0] corr;
      logic        empty;
   } corr_result_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // One directed step: a pixel word, or a register write (a = index, b = value)
   typedef struct {
      row_kind_type kind;
      int           a;
      int           b;
      bit           mask;
      bit           last;
      bit           typed;
      logic [17:0]  corr;
      bit           empty;
   } stim_row_type;

   localparam logic [17:0] CORR_ONE       = 18'h10000;
   localparam logic [17:0] CORR_MINUS_ONE = 18'h30000;
   localparam int          N_DIRECTED     = 24;
   localparam int          PHASE_WORDS    = 110;
   localparam int          HOLD_AT_RESULT = 25;
   localparam int          HOLD_CYCLES    = 250;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // pixel_a, pixel_b
   logic        req_tlast;    // last_pixel
   logic        req_tuser;    // in_mask
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // correlation, zero fill
   logic        rsp_tuser;    // empty_res
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: configuration and the three running sums
   logic        cfg_mask_enable;
   logic        cfg_mask_invert;
   logic [55:0] acc_cross;
   logic [54:0] acc_sq_a;
   logic [54:0] acc_sq_b;

   corr_result_type expected_corr[$];
   int              error_count;
   int              words_sent;
   int              results_seen;

   int phase_enable[4] = '{0, 1, 1, 0};
   int phase_invert[4] = '{1, 0, 1, 0};

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_WORD, 0, 0, 1'b0, 1'b1, 1'b1, 18'd0, 1'b1},
      '{ROW_WORD, 1234, 0, 1'b1, 1'b1, 1'b1, 18'd0, 1'b1},
      '{ROW_WORD, 5, 5, 1'b0, 1'b1, 1'b1, CORR_ONE, 1'b0},
      '{ROW_WORD, 5, -5, 1'b1, 1'b1, 1'b1, CORR_MINUS_ONE, 1'b0},
      '{ROW_WORD, 32767, 32767, 1'b0, 1'b1, 1'b1, CORR_ONE, 1'b0},
      '{ROW_WORD, -32768, -32768, 1'b1, 1'b1, 1'b1, CORR_ONE, 1'b0},
      '{ROW_WORD, -32768, 32767, 1'b0, 1'b1, 1'b1, CORR_MINUS_ONE, 1'b0},
      '{ROW_WORD, 1, 1, 1'b0, 1'b0, 1'b0, 18'd0, 1'b0},
      '{ROW_WORD, 1, -1, 1'b1, 1'b1, 1'b1, 18'd0, 1'b0},
      '{ROW_WORD, 3, -4, 1'b0, 1'b0, 1'b0, 18'd0, 1'b0},
      '{ROW_WORD, 0, 7, 1'b1, 1'b0, 1'b0, 18'd0, 1'b0},
      '{ROW_WORD, -32768, 12345, 1'b0, 1'b1, 1'b0, 18'd0, 1'b0},
      '{ROW_CSR, REG_MASK_ENABLE, 1, 1'b0, 1'b0, 1'b0, 18'd0, 1'b0},
      '{ROW_WORD, 9, 9, 1'b0, 1'b1, 1'b1, 18'd0, 1'b1},
      '{ROW_WORD, 9, -9, 1'b1, 1'b1, 1'b1, CORR_MINUS_ONE, 1'b0},
      '{ROW_CSR, REG_MASK_INVERT, 1, 1'b0, 1'b0, 1'b0, 18'd0, 1'b0},
      '{ROW_WORD, 9, 9, 1'b1, 1'b1, 1'b1, 18'd0, 1'b1},
      '{ROW_WORD, 7, 3, 1'b0, 1'b0, 1'b0, 18'd0, 1'b0},
      '{ROW_WORD, 2, 100, 1'b1, 1'b0, 1'b0, 18'd0, 1'b0},
      '{ROW_WORD, -6, -5, 1'b0, 1'b1, 1'b0, 18'd0, 1'b0},
      '{ROW_CSR, REG_MASK_ENABLE, 0, 1'b0, 1'b0, 1'b0, 18'd0, 1'b0},
      '{ROW_WORD, 4, 8, 1'b1, 1'b0, 1'b0, 18'd0, 1'b0},
      '{ROW_WORD, -32768, -32768, 1'b0, 1'b1, 1'b0, 18'd0, 1'b0},
      '{ROW_CSR, REG_MASK_INVERT, 0, 1'b0, 1'b0, 1'b0, 18'd0, 1'b0}
   };

   masked_normalized_cross_correlation u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   // Idle stretches: every fourth block of 40 words runs with no waits at all
   function automatic int draw_wait(input int count);
      if ((count / 40) % 4 == 1) return 0;
      return $urandom_range(0, 14);
   endfunction

   // Accumulate one pixel pair; on the last pixel work out the Q1.16 correlation
   task automatic correlate_pixel(input pixel_type a, input pixel_type b, input logic in_mask,
                                  input logic last, output bit produced,
                                  output corr_result_type res);
      logic signed [31:0] ab;
      logic signed [31:0] aa;
      logic signed [31:0] bb;
      logic [55:0]        c;
      logic [55:0]        c_mag;
      logic [159:0]       mag;
      logic [159:0]       target;
      logic [159:0]       sq_prod;
      logic [159:0]       trial;
      logic [16:0]        q;
      logic [16:0]        cand;
      logic               neg;
      logic               pick;
      pick = cfg_mask_enable ? (in_mask ^ cfg_mask_invert) : 1'b1;
      if (pick && a != 0 && b != 0) begin
         ab = a * b;
         aa = a * a;
         bb = b * b;
         acc_cross = acc_cross + {{24{ab[31]}}, ab};
         acc_sq_a  = acc_sq_a + {23'd0, aa};
         acc_sq_b  = acc_sq_b + {23'd0, bb};
      end
      produced = last;
      res = '0;
      if (!last) return;
      if (acc_sq_a == 0 || acc_sq_b == 0) begin
         res.empty = 1'b1;
      end else begin
         c = acc_cross;
         neg = c[55];
         // magnitude at the width of the cross sum
         c_mag = neg ? (~c + 56'd1) : c;
         mag = 160'(c_mag);
         target = (mag * mag) << 32;
         sq_prod = 160'(acc_sq_a) * 160'(acc_sq_b);
         q = '0;
         // build the quotient bit by bit, never above one
         for (int k = 16; k >= 0; k--) begin
            cand = q | (17'd1 << k);
            if (cand <= 17'h10000) begin
               trial = 160'(cand) * 160'(cand) * sq_prod;
               if (trial <= target) q = cand;
            end
         end
         res.corr = neg ? (18'd0 - {1'b0, q}) : {1'b0, q};
      end
      acc_cross = '0;
      acc_sq_a  = '0;
      acc_sq_b  = '0;
   endtask

   // Offer one pixel word, hold it until taken, then queue what it should produce
   task automatic send_word(input pixel_type a, input pixel_type b, input logic in_mask,
                            input logic last, input bit typed, input logic [17:0] corr,
                            input logic empty);
      int              gap;
      bit              produced;
      corr_result_type res;
      gap = draw_wait(words_sent);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tlast  <= $urandom_range(0, 1);
         req_tuser  <= $urandom_range(0, 1);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tlast  <= last;
      req_tuser  <= in_mask;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      correlate_pixel(a, b, in_mask, last, produced, res);
      if (produced) begin
         if (typed) begin
            res.corr  = corr;
            res.empty = empty;
         end
         expected_corr.push_back(res);
      end
   endtask

   // Drop valid, drain every pending result and let the block settle
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_corr.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(input logic reg_index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (reg_index)
         REG_MASK_ENABLE: cfg_mask_enable = value[0];
         REG_MASK_INVERT: cfg_mask_invert = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic pixel_type random_pixel();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         4, 5: return pixel_type'($urandom_range(0, 32)) - 16'sd16;
         default: return pixel_type'($urandom);
      endcase
   endfunction

   // One image pair: mostly short, sometimes long; b is drawn on its own or tracks a in several ways
   task automatic send_frame();
      int        len;
      int        mode;
      pixel_type a;
      pixel_type b;
      case ($urandom_range(0, 19)) inside
         [0:13]:  len = $urandom_range(1, 6);
         [14:18]: len = $urandom_range(7, 20);
         default: len = $urandom_range(21, 60);
      endcase
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         a = random_pixel();
         case (mode)
            0: b = random_pixel();
            1: b = a;
            2: b = -a;
            default: b = a + pixel_type'($urandom_range(0, 6)) - 16'sd3;
         endcase
         send_word(a, b, $urandom_range(0, 1), i == len - 1, 1'b0, 18'd0, 1'b0);
      end
   endtask

   // Result side: random stalls, one long hold-off, compare against the oldest expectation
   initial begin
      int              stall;
      corr_result_type want;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = (results_seen == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_wait(results_seen);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_seen++;
         if (expected_corr.size() == 0) begin
            report_mismatch($sformatf("unexpected result word, data %h user %b",
                                      rsp_tdata, rsp_tuser));
         end else begin
            want = expected_corr.pop_front();
            if (rsp_tdata[17:0] !== want.corr)
               report_mismatch($sformatf("result %0d: correlation %0d, expected %0d",
                                         results_seen, $signed(rsp_tdata[17:0]),
                                         $signed(want.corr)));
            if (rsp_tuser !== want.empty)
               report_mismatch($sformatf("result %0d: empty flag %b, expected %b",
                                         results_seen, rsp_tuser, want.empty));
         end
      end
   end

   // Stimulus: reset, directed table, then random phases over the register settings
   initial begin
      int phase_start;
      error_count     = 0;
      words_sent      = 0;
      results_seen    = 0;
      cfg_mask_enable = 1'b0;
      cfg_mask_invert = 1'b0;
      acc_cross       = '0;
      acc_sq_a        = '0;
      acc_sq_b        = '0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle();
            write_csr(directed_rows[i].a[0], directed_rows[i].b);
         end else begin
            send_word(pixel_type'(directed_rows[i].a), pixel_type'(directed_rows[i].b),
                      directed_rows[i].mask, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].corr,
                      directed_rows[i].empty);
         end
      end

      for (int p = 0; p < 4; p++) begin
         settle();
         write_csr(REG_MASK_ENABLE, phase_enable[p]);
         write_csr(REG_MASK_INVERT, phase_invert[p]);
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) send_frame();
      end

      settle();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
sv/mncc_pkg.sv
sv/mncc_addsub.sv
sv/mncc_pixmul.sv
sv/masked_normalized_cross_correlation.sv
sim/tb.sv
